// ===== hw/rtl/wdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph edge table package
// Operation codes, status codes and the controller state type.
// ----------------------------------------------------------------------------
package wdg_pkg;

	localparam int OP_BITS     = 3;
	localparam int VERTEX_BITS = 5;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int STATUS_BITS = 2;
	localparam int ANSWER_BITS = 16;
	localparam int VCOUNT_BITS = 6;

	localparam logic [OP_BITS-1:0] OP_ADD_EDGE  = 3'd0;
	localparam logic [OP_BITS-1:0] OP_SET_WEIGHT = 3'd1;
	localparam logic [OP_BITS-1:0] OP_REMOVE    = 3'd2;
	localparam logic [OP_BITS-1:0] OP_OUT_DEG   = 3'd3;
	localparam logic [OP_BITS-1:0] OP_IN_DEG    = 3'd4;
	localparam logic [OP_BITS-1:0] OP_MAX_WEIGHT = 3'd5;

	localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_RANGE   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_EXISTS  = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_MISSING = 2'd3;

	// Register index 0 (vertex_count) sits at byte address 0.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN
	} ctrl_state_t;

endpackage

// ===== hw/rtl/wdg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/weighted_digraph_edge_table_core.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph edge table core
// Directed weighted graph kept as a presence store and a weight store, with
// per-vertex out-degree and in-degree counters, all in synchronous RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+-----------------------------------
//  command  | start high while busy low     | operation, source_vertex,
//           |                               | dest_vertex, new_weight
//  result   | done high for one cycle       | status, answer
//  config   | APB write: psel penable pwrite| paddr, pwdata (prdata on read)
//
// Add, set weight, remove and degree queries do one RAM read, then the modify
// and write back. Maximum weight scans all n*n edge slots of n live vertices,
// one edge read per cycle through the presence and weight RAMs.
// After reset and after each write of vertex_count a clearing pass over every
// edge slot holds busy high while the presence store and counters are zeroed.
// The result is registered; the next command may be taken while it is shown.
// ----------------------------------------------------------------------------
module weighted_digraph_edge_table_core #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command
	input  logic                                 start,
	output logic                                 busy,
	input  logic [wdg_pkg::OP_BITS-1:0]          operation,
	input  logic [wdg_pkg::VERTEX_BITS-1:0]      source_vertex,
	input  logic [wdg_pkg::VERTEX_BITS-1:0]      dest_vertex,
	input  logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] new_weight,
	// result
	output logic                                 done,
	output logic [wdg_pkg::STATUS_BITS-1:0]      status,
	output logic signed [wdg_pkg::ANSWER_BITS-1:0] answer,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int EDEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int EAW   = $clog2(EDEPTH);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int WHI   = (1 << (WB - 1)) - 1;
	localparam int WLO   = -WHI - 1;

	function automatic logic [EAW-1:0] edge_addr(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] t;
		t = a * MAX_VERTICES + b;
		return t[EAW-1:0];
	endfunction

	wdg_pkg::ctrl_state_t state_q, state_nx;

	logic [wdg_pkg::VCOUNT_BITS-1:0] vcount_q;
	logic [CW-1:0]                   live;
	logic                            cfg_wr;
	logic                            accept;

	logic [EAW-1:0] clr_q;
	logic [VB-1:0]  scan_a_q, scan_b_q;
	logic           scan_last;
	logic           rd_vld_s1;
	logic signed [WB-1:0] max_q, max_nx;

	logic [wdg_pkg::OP_BITS-1:0] op_s1;
	logic [VB-1:0]               u_s1, v_s1;
	logic [EAW-1:0]              eaddr_s1;
	logic signed [WB-1:0]        w_s1;
	logic                        rng_bad_s1;

	logic                   in_u_ok, in_v_ok, in_rng_bad;
	logic signed [WB-1:0]   w_clamped;

	// RAM ports
	logic           pres_we, pres_wd, pres_rd;
	logic [EAW-1:0] pres_wa, edge_ra;
	logic           wt_we;
	logic signed [WB-1:0] wt_wd, wt_rd;
	logic           oc_we, ic_we;
	logic [VB-1:0]  oc_wa, ic_wa, oc_ra, ic_ra;
	logic [CW-1:0]  oc_wd, ic_wd, oc_rd, ic_rd;

	logic                                  res_fire;
	logic [wdg_pkg::STATUS_BITS-1:0]       res_status;
	logic signed [wdg_pkg::ANSWER_BITS-1:0] res_answer;

	logic                                  done_q;
	logic [wdg_pkg::STATUS_BITS-1:0]       status_q;
	logic signed [wdg_pkg::ANSWER_BITS-1:0] answer_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == wdg_pkg::REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == wdg_pkg::REG_VERTEX_COUNT) ?
		{{(32 - wdg_pkg::VCOUNT_BITS){1'b0}}, vcount_q} : 32'd0;

	// A count above the store size acts as the store size.
	assign live = (32'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_q);

	assign busy   = (state_q != wdg_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign in_u_ok = 32'(source_vertex) < 32'(live);
	assign in_v_ok = 32'(dest_vertex) < 32'(live);

	always_comb begin
		case (operation)
			wdg_pkg::OP_ADD_EDGE,
			wdg_pkg::OP_SET_WEIGHT,
			wdg_pkg::OP_REMOVE: in_rng_bad = !(in_u_ok && in_v_ok);
			wdg_pkg::OP_OUT_DEG: in_rng_bad = !in_u_ok;
			wdg_pkg::OP_IN_DEG:  in_rng_bad = !in_v_ok;
			default:             in_rng_bad = 1'b0;
		endcase
	end

	always_comb begin
		if (32'(signed'(new_weight)) > WHI) begin
			w_clamped = WB'(WHI);
		end else if (32'(signed'(new_weight)) < WLO) begin
			w_clamped = WB'(WLO);
		end else begin
			w_clamped = WB'(new_weight);
		end
	end

	assign scan_last = (32'(scan_a_q) == 32'(live) - 1) && (32'(scan_b_q) == 32'(live) - 1);

	// Running maximum; absent edges never take part.
	assign max_nx = (rd_vld_s1 && pres_rd && (wt_rd > max_q)) ? wt_rd : max_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			wdg_pkg::ST_CLEAR: begin
				if (clr_q == EAW'(EDEPTH - 1)) begin
					state_nx = wdg_pkg::ST_IDLE;
				end
			end
			wdg_pkg::ST_IDLE: begin
				if (accept) begin
					if ((operation == wdg_pkg::OP_MAX_WEIGHT) && (live != '0)) begin
						state_nx = wdg_pkg::ST_SCAN;
					end else begin
						state_nx = wdg_pkg::ST_EXEC;
					end
				end
			end
			wdg_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_nx = wdg_pkg::ST_DRAIN;
				end
			end
			wdg_pkg::ST_EXEC,
			wdg_pkg::ST_DRAIN: state_nx = wdg_pkg::ST_IDLE;
			default: state_nx = wdg_pkg::ST_CLEAR;
		endcase
		if (cfg_wr) begin
			state_nx = wdg_pkg::ST_CLEAR;
		end
	end

	// Outputs: RAM controls and the result
	always_comb begin
		pres_we = 1'b0;
		pres_wa = eaddr_s1;
		pres_wd = 1'b0;
		wt_we   = 1'b0;
		wt_wd   = '0;
		oc_we   = 1'b0;
		ic_we   = 1'b0;
		oc_wa   = u_s1;
		ic_wa   = v_s1;
		oc_wd   = oc_rd;
		ic_wd   = ic_rd;
		edge_ra = edge_addr(32'(source_vertex), 32'(dest_vertex));
		oc_ra   = VB'(source_vertex);
		ic_ra   = VB'(dest_vertex);
		res_fire   = 1'b0;
		res_status = wdg_pkg::STAT_OK;
		res_answer = '0;
		case (state_q)
			wdg_pkg::ST_CLEAR: begin
				pres_we = 1'b1;
				pres_wa = clr_q;
				if (32'(clr_q) < MAX_VERTICES) begin
					oc_we = 1'b1;
					ic_we = 1'b1;
					oc_wa = VB'(clr_q);
					ic_wa = VB'(clr_q);
					oc_wd = '0;
					ic_wd = '0;
				end
			end
			wdg_pkg::ST_SCAN: begin
				edge_ra = edge_addr(32'(scan_a_q), 32'(scan_b_q));
			end
			wdg_pkg::ST_DRAIN: begin
				res_fire   = 1'b1;
				res_answer = wdg_pkg::ANSWER_BITS'(max_nx);
			end
			wdg_pkg::ST_EXEC: begin
				res_fire = 1'b1;
				case (op_s1)
					wdg_pkg::OP_ADD_EDGE: begin
						if (rng_bad_s1) begin
							res_status = wdg_pkg::STAT_RANGE;
						end else if (pres_rd) begin
							res_status = wdg_pkg::STAT_EXISTS;
						end else begin
							pres_we = 1'b1;
							pres_wd = 1'b1;
							wt_we   = 1'b1;
							wt_wd   = '0;
							oc_we   = 1'b1;
							ic_we   = 1'b1;
							oc_wd   = oc_rd + CW'(1);
							ic_wd   = ic_rd + CW'(1);
						end
					end
					wdg_pkg::OP_SET_WEIGHT: begin
						if (rng_bad_s1) begin
							res_status = wdg_pkg::STAT_RANGE;
						end else if (!pres_rd) begin
							res_status = wdg_pkg::STAT_MISSING;
						end else begin
							wt_we = 1'b1;
							wt_wd = w_s1;
						end
					end
					wdg_pkg::OP_REMOVE: begin
						if (rng_bad_s1) begin
							res_status = wdg_pkg::STAT_RANGE;
						end else if (!pres_rd) begin
							res_status = wdg_pkg::STAT_MISSING;
						end else begin
							pres_we = 1'b1;
							pres_wd = 1'b0;
							oc_we   = 1'b1;
							ic_we   = 1'b1;
							oc_wd   = oc_rd - CW'(1);
							ic_wd   = ic_rd - CW'(1);
						end
					end
					wdg_pkg::OP_OUT_DEG: begin
						if (rng_bad_s1) begin
							res_status = wdg_pkg::STAT_RANGE;
						end else begin
							res_answer = wdg_pkg::ANSWER_BITS'(oc_rd);
						end
					end
					wdg_pkg::OP_IN_DEG: begin
						if (rng_bad_s1) begin
							res_status = wdg_pkg::STAT_RANGE;
						end else begin
							res_answer = wdg_pkg::ANSWER_BITS'(ic_rd);
						end
					end
					wdg_pkg::OP_MAX_WEIGHT: begin
						// Only reached with no live vertices: the maximum stays at zero.
						res_answer = wdg_pkg::ANSWER_BITS'(max_q);
					end
					default: begin
						res_status = wdg_pkg::STAT_OK;
					end
				endcase
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wdg_pkg::ST_CLEAR;
			vcount_q <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_nx;
			done_q    <= res_fire;
			rd_vld_s1 <= (state_q == wdg_pkg::ST_SCAN);
			if (cfg_wr) begin
				vcount_q <= pwdata[wdg_pkg::VCOUNT_BITS-1:0];
				clr_q    <= '0;
			end else if (state_q == wdg_pkg::ST_CLEAR) begin
				clr_q <= clr_q + EAW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			u_s1       <= VB'(source_vertex);
			v_s1       <= VB'(dest_vertex);
			eaddr_s1   <= edge_addr(32'(source_vertex), 32'(dest_vertex));
			w_s1       <= w_clamped;
			rng_bad_s1 <= in_rng_bad;
			scan_a_q   <= '0;
			scan_b_q   <= '0;
			max_q      <= '0;
		end else begin
			max_q <= max_nx;
			if (state_q == wdg_pkg::ST_SCAN) begin
				if (32'(scan_b_q) == 32'(live) - 1) begin
					scan_b_q <= '0;
					scan_a_q <= scan_a_q + VB'(1);
				end else begin
					scan_b_q <= scan_b_q + VB'(1);
				end
			end
		end
		if (res_fire) begin
			status_q <= res_status;
			answer_q <= res_answer;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign answer = answer_q;

	wdg_ram #(.WIDTH(1), .DEPTH(EDEPTH)) u_pres_ram (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_wa),
		.wdata (pres_wd),
		.raddr (edge_ra),
		.rdata (pres_rd)
	);

	wdg_ram #(.WIDTH(WB), .DEPTH(EDEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (eaddr_s1),
		.wdata (wt_wd),
		.raddr (edge_ra),
		.rdata (wt_rd)
	);

	wdg_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_out_ram (
		.clk   (clk),
		.we    (oc_we),
		.waddr (oc_wa),
		.wdata (oc_wd),
		.raddr (oc_ra),
		.rdata (oc_rd)
	);

	wdg_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_in_ram (
		.clk   (clk),
		.we    (ic_we),
		.waddr (ic_wa),
		.wdata (ic_wd),
		.raddr (ic_ra),
		.rdata (ic_rd)
	);

endmodule

// ===== hw/rtl/wdg_checker.sv =====
// ----------------------------------------------------------------------------
// Weighted digraph edge table port checker
// Watches the command, result and configuration ports of the core over time.
// ----------------------------------------------------------------------------
module wdg_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic [wdg_pkg::OP_BITS-1:0]           operation,
	input logic                                  done,
	input logic [wdg_pkg::STATUS_BITS-1:0]       status,
	input logic signed [wdg_pkg::ANSWER_BITS-1:0] answer,
	input logic                                  psel,
	input logic                                  penable,
	input logic                                  pwrite
);

	// An accepted command always occupies the core for the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("core took a command but was not busy afterwards");

	// Results never come in consecutive cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// Short operations pass the execute state and the done register, unless reconfigured.
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation != wdg_pkg::OP_MAX_WEIGHT)
			##1 !(psel && penable && pwrite)) |=> done)
		else $error("short operation did not complete in two cycles");

	// A failing status never carries an answer.
	a_answer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != wdg_pkg::STAT_OK) |-> (answer == '0))
		else $error("non-zero answer with an error status");

endmodule

bind weighted_digraph_edge_table_core wdg_checker u_wdg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.done      (done),
	.status    (status),
	.answer    (answer),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite)
);

// ===== tb/sv/weighted_digraph_edge_table_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted digraph edge table core testbench
// Drives edge commands and vertex-count writes into the core and predicts
// every status and answer from a private copy of the edge store.
// ----------------------------------------------------------------------------
module weighted_digraph_edge_table_core_test;

	localparam int MAX_V = 32;
	localparam int WEIGHT_BITS = 16;
	localparam int STORED_BITS = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam logic [wdg_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [wdg_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;
	localparam logic [2:0] VCOUNT_ADDR = 3'(4 * wdg_pkg::REG_VERTEX_COUNT);

	typedef struct packed {
		logic [wdg_pkg::STATUS_BITS-1:0]        status;
		logic signed [wdg_pkg::ANSWER_BITS-1:0] answer;
	} edge_result_t;

	class edge_table_scoreboard;
		edge_result_t                                 awaited[$];
		int unsigned                                  errors;
		logic [wdg_pkg::VCOUNT_BITS-1:0]              vcount;
		bit                                           present[MAX_V][MAX_V];
		logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0]    weight[MAX_V][MAX_V];
		logic [5:0]                                   out_deg[MAX_V];
		logic [5:0]                                   in_deg[MAX_V];

		function new();
			errors = 0;
			set_vertex_count('0);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("ERROR at %0d ns: %s", $time, msg);
		endtask

		// Writing the vertex count starts a fresh, empty graph.
		function void set_vertex_count(logic [wdg_pkg::VCOUNT_BITS-1:0] value);
			vcount = value;
			for (int a = 0; a < MAX_V; a++) begin
				out_deg[a] = '0;
				in_deg[a] = '0;
				for (int b = 0; b < MAX_V; b++) begin
					present[a][b] = 1'b0;
					weight[a][b] = '0;
				end
			end
		endfunction

		function int live_vertices();
			return (vcount > MAX_V) ? MAX_V : int'(vcount);
		endfunction

		function logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] saturate(
				logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] w);
			int hi;
			int lo;
			hi = (1 << (STORED_BITS - 1)) - 1;
			lo = -hi - 1;
			if (w > hi)
				return wdg_pkg::WEIGHT_IN_BITS'(hi);
			if (w < lo)
				return wdg_pkg::WEIGHT_IN_BITS'(lo);
			return w;
		endfunction

		function void note_command(logic [wdg_pkg::OP_BITS-1:0] op,
				logic [wdg_pkg::VERTEX_BITS-1:0] u, logic [wdg_pkg::VERTEX_BITS-1:0] v,
				logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] w);
			edge_result_t                           e;
			int                                     n;
			bit                                     u_ok;
			bit                                     v_ok;
			logic signed [wdg_pkg::ANSWER_BITS-1:0] best;
			n = live_vertices();
			u_ok = int'(u) < n;
			v_ok = int'(v) < n;
			e.status = wdg_pkg::STAT_OK;
			e.answer = '0;
			case (op)
			wdg_pkg::OP_ADD_EDGE: begin
				if (!(u_ok && v_ok))
					e.status = wdg_pkg::STAT_RANGE;
				else if (present[u][v])
					e.status = wdg_pkg::STAT_EXISTS;
				else begin
					present[u][v] = 1'b1;
					weight[u][v] = '0;
					out_deg[u]++;
					in_deg[v]++;
				end
			end
			wdg_pkg::OP_SET_WEIGHT: begin
				if (!(u_ok && v_ok))
					e.status = wdg_pkg::STAT_RANGE;
				else if (!present[u][v])
					e.status = wdg_pkg::STAT_MISSING;
				else
					weight[u][v] = saturate(w);
			end
			wdg_pkg::OP_REMOVE: begin
				if (!(u_ok && v_ok))
					e.status = wdg_pkg::STAT_RANGE;
				else if (!present[u][v])
					e.status = wdg_pkg::STAT_MISSING;
				else begin
					present[u][v] = 1'b0;
					out_deg[u]--;
					in_deg[v]--;
				end
			end
			wdg_pkg::OP_OUT_DEG: begin
				if (!u_ok)
					e.status = wdg_pkg::STAT_RANGE;
				else
					e.answer = wdg_pkg::ANSWER_BITS'(out_deg[u]);
			end
			wdg_pkg::OP_IN_DEG: begin
				if (!v_ok)
					e.status = wdg_pkg::STAT_RANGE;
				else
					e.answer = wdg_pkg::ANSWER_BITS'(in_deg[v]);
			end
			wdg_pkg::OP_MAX_WEIGHT: begin
				// The running maximum starts at zero, so negative weights never show.
				best = '0;
				for (int a = 0; a < n; a++)
					for (int b = 0; b < n; b++)
						if (present[a][b] && weight[a][b] > best)
							best = weight[a][b];
				e.answer = best;
			end
			default: ;
			endcase
			awaited.push_back(e);
		endfunction

		task check_result(logic [wdg_pkg::STATUS_BITS-1:0] st,
				logic signed [wdg_pkg::ANSWER_BITS-1:0] ans);
			edge_result_t e;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result: status %0d answer %0d", st, ans));
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
			if (ans !== e.answer)
				report_mismatch($sformatf("answer %0d, expected %0d", ans, e.answer));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [wdg_pkg::OP_BITS-1:0] operation;
	logic [wdg_pkg::VERTEX_BITS-1:0] source_vertex;
	logic [wdg_pkg::VERTEX_BITS-1:0] dest_vertex;
	logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] new_weight;
	logic done;
	logic [wdg_pkg::STATUS_BITS-1:0] status;
	logic signed [wdg_pkg::ANSWER_BITS-1:0] answer;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	edge_table_scoreboard sb;
	bit steady;

	weighted_digraph_edge_table_core #(
		.MAX_VERTICES(MAX_V),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.source_vertex(source_vertex),
		.dest_vertex  (dest_vertex),
		.new_weight   (new_weight),
		.done         (done),
		.status       (status),
		.answer       (answer),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, answer);
	end

	// Start is left high after a transfer so that back-to-back commands need
	// no gap; any idle cycle lowers it at the falling edge.
	task automatic send_command(logic [wdg_pkg::OP_BITS-1:0] op,
			logic [wdg_pkg::VERTEX_BITS-1:0] u, logic [wdg_pkg::VERTEX_BITS-1:0] v,
			logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] w);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		source_vertex <= u;
		dest_vertex <= v;
		new_weight <= w;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(op, u, v, w);
	endtask

	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_vertices(logic [wdg_pkg::VCOUNT_BITS-1:0] value);
		quiesce();
		while (busy)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= VCOUNT_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_vertex_count(value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== 32'(value))
			sb.report_mismatch($sformatf("vertex_count reads %0d, expected %0d", prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [wdg_pkg::VERTEX_BITS-1:0] pick_vertex(int n);
		int r;
		r = $urandom_range(0, 99);
		// A small hot set makes repeated adds, weight updates and removals likely.
		if (n > 0 && r < 50)
			return wdg_pkg::VERTEX_BITS'($urandom_range(0, ((n < 4) ? n : 4) - 1));
		if (n > 0 && r < 88)
			return wdg_pkg::VERTEX_BITS'($urandom_range(0, n - 1));
		return wdg_pkg::VERTEX_BITS'($urandom_range(0, MAX_V - 1));
	endfunction

	function automatic logic signed [wdg_pkg::WEIGHT_IN_BITS-1:0] pick_weight();
		case ($urandom_range(0, 9))
		0: return 16'sh7fff;
		1: return 16'sh8000;
		2: return '0;
		3: return -16'sd1;
		4: return 16'sd1;
		default: return wdg_pkg::WEIGHT_IN_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [wdg_pkg::OP_BITS-1:0] pick_operation();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return wdg_pkg::OP_ADD_EDGE;
		if (r < 50) return wdg_pkg::OP_SET_WEIGHT;
		if (r < 68) return wdg_pkg::OP_REMOVE;
		if (r < 79) return wdg_pkg::OP_OUT_DEG;
		if (r < 90) return wdg_pkg::OP_IN_DEG;
		if (r < 94) return wdg_pkg::OP_MAX_WEIGHT;
		return (r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
	endfunction

	task automatic run_phase(logic [wdg_pkg::VCOUNT_BITS-1:0] count, int items,
			bit hold_midway);
		int n;
		set_vertices(count);
		n = (count > MAX_V) ? MAX_V : int'(count);
		for (int k = 0; k < items; k++) begin
			if (hold_midway && k == items / 2)
				quiesce();
			send_command(pick_operation(), pick_vertex(n), pick_vertex(n), pick_weight());
		end
	endtask

	initial begin
		int phase_count[8] = '{8, 32, 63, 2, 1, 0, 17, 33};
		int phase_items[8] = '{200, 180, 150, 120, 60, 50, 160, 80};
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = wdg_pkg::OP_ADD_EDGE;
		source_vertex = '0;
		dest_vertex = '0;
		new_weight = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on a four-vertex graph.
		set_vertices(6'd4);
		send_command(wdg_pkg::OP_OUT_DEG, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_MAX_WEIGHT, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd0, 5'd0, 16'sh7fff);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd3, 5'd3, '0);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd4, 5'd0, '0);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd0, 5'd31, '0);
		send_command(wdg_pkg::OP_MAX_WEIGHT, 5'd31, 5'd31, '0);
		send_command(wdg_pkg::OP_SET_WEIGHT, 5'd0, 5'd0, 16'sh7fff);
		send_command(wdg_pkg::OP_SET_WEIGHT, 5'd3, 5'd3, 16'sh8000);
		send_command(wdg_pkg::OP_SET_WEIGHT, 5'd1, 5'd2, 16'sd7);
		send_command(wdg_pkg::OP_SET_WEIGHT, 5'd31, 5'd0, 16'sd7);
		send_command(wdg_pkg::OP_MAX_WEIGHT, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_SET_WEIGHT, 5'd0, 5'd0, -16'sd5);
		send_command(wdg_pkg::OP_MAX_WEIGHT, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_OUT_DEG, 5'd0, 5'd31, '0);
		send_command(wdg_pkg::OP_IN_DEG, 5'd31, 5'd3, '0);
		send_command(wdg_pkg::OP_OUT_DEG, 5'd31, 5'd0, '0);
		send_command(wdg_pkg::OP_IN_DEG, 5'd0, 5'd4, '0);
		send_command(wdg_pkg::OP_REMOVE, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_REMOVE, 5'd0, 5'd0, '0);
		send_command(wdg_pkg::OP_REMOVE, 5'd9, 5'd1, '0);
		send_command(OP_SPARE_LO, 5'd31, 5'd31, 16'sh7fff);
		send_command(OP_SPARE_HI, 5'd0, 5'd0, 16'sh8000);
		send_command(wdg_pkg::OP_ADD_EDGE, 5'd1, 5'd2, '0);

		for (int p = 0; p < 8; p++) begin
			steady = (p == 1);
			run_phase(wdg_pkg::VCOUNT_BITS'(phase_count[p]), phase_items[p], p == 6);
		end
		steady = 1'b0;

		@(negedge clk);
		start <= 1'b0;
		for (int i = 0; i < 20000 && sb.awaited.size() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
		if (sb.errors == 0)
			$display("weighted_digraph_edge_table_core: match");
		else
			$display("weighted_digraph_edge_table_core: mismatch");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("weighted_digraph_edge_table_core: mismatch");
		$finish;
	end

endmodule
